FILE: src/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press classifier modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int TICKS_W    = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;

	localparam logic               ENABLE_RST     = 1'b1;
	localparam logic [TICKS_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [TICKS_W-1:0] LONG_PRESS_RST = 16'd1000;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_HELD     = 2'd2
	} phase_t;

	typedef struct packed {
		logic rise_edge;
		logic tick;
		logic pin_level;
	} in_t;

	typedef struct packed {
		logic short_press;
		logic long_press;
	} out_t;

	typedef struct packed {
		logic               enable;
		logic [TICKS_W-1:0] debounce_ticks;
		logic [TICKS_W-1:0] long_press_ticks;
	} cfg_t;

endpackage

FILE: src/bpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bpc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bpc_pkg::cfg_t                    cfg
);

	bpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= bpc_pkg::ENABLE_RST;
			cfg_q.debounce_ticks   <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ticks <= bpc_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::CFG_ENABLE:     cfg_q.enable           <= cfg_data[0];
				bpc_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data[bpc_pkg::TICKS_W-1:0];
				bpc_pkg::CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data[bpc_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/bpc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_core
// Pending latches, phase machine, saturating tick counter and press flags.
// The flag registers are the result register of the block.
// ----------------------------------------------------------------------------
module bpc_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  bpc_pkg::in_t  item,
	input  bpc_pkg::cfg_t cfg,
	output bpc_pkg::out_t result
);

	localparam int CMP_W = (COUNT_BITS > bpc_pkg::TICKS_W) ? COUNT_BITS : bpc_pkg::TICKS_W;

	bpc_pkg::phase_t phase_q, phase_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic edge_q, edge_d, tick_q, tick_d;
	logic short_q, short_d, long_q, long_d;
	logic edge_p, tick_p;
	logic [CMP_W-1:0] cnt_ext, deb_ext, long_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpc_pkg::PH_IDLE;
			cnt_q   <= '0;
			edge_q  <= 1'b0;
			tick_q  <= 1'b0;
			short_q <= 1'b0;
			long_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			edge_q  <= edge_d;
			tick_q  <= tick_d;
			short_q <= short_d;
			long_q  <= long_d;
		end
	end

	// saturating increment
	assign cnt_inc  = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign cnt_ext  = CMP_W'(cnt_inc);
	assign deb_ext  = CMP_W'(cfg.debounce_ticks);
	assign long_ext = CMP_W'(cfg.long_press_ticks);
	assign edge_p   = edge_q | item.rise_edge;
	assign tick_p   = tick_q | item.tick;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		edge_d  = edge_p;
		tick_d  = tick_p;
		short_d = short_q;
		long_d  = long_q;
		if (cfg.enable) begin
			case (phase_q)
				bpc_pkg::PH_DEBOUNCE: begin
					if (tick_p) begin
						tick_d = 1'b0;
						cnt_d  = cnt_inc;
						if (cnt_ext >= deb_ext)
							phase_d = item.pin_level ? bpc_pkg::PH_HELD : bpc_pkg::PH_IDLE;
					end
				end
				bpc_pkg::PH_HELD: begin
					if (tick_p) begin
						tick_d = 1'b0;
						cnt_d  = cnt_inc;
						if (!item.pin_level) begin
							long_d  = cnt_ext > long_ext;
							short_d = !(cnt_ext > long_ext);
							phase_d = bpc_pkg::PH_IDLE;
						end
					end
				end
				default: begin
					// idle, and the unused code behaves as idle
					phase_d = bpc_pkg::PH_IDLE;
					cnt_d   = '0;
					short_d = 1'b0;
					long_d  = 1'b0;
					if (edge_p) begin
						edge_d  = 1'b0;
						phase_d = bpc_pkg::PH_DEBOUNCE;
					end
				end
			endcase
		end
	end

	assign result.short_press = short_q;
	assign result.long_press  = long_q;

endmodule

FILE: src/button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced short / long press detector, one polling step per request.
// ----------------------------------------------------------------------------
// Each input request is one polling step (edge event, tick, pin level) and
// yields exactly one result request carrying the short and long press flags.
// A request is latched in an input register; once the flag registers are free,
// the step logic updates the phase machine, counter and flag registers, and the
// flags are the output register. Throughput is one request per clock unless
// out_stall holds the output. The counter is COUNT_BITS wide and saturates.
// Configuration writes are taken at any time, but are meant to happen only
// while no request is in flight.
module button_press_classifier #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bpc_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bpc_pkg::out_t                  out_data
);

	bpc_pkg::cfg_t cfg;
	bpc_pkg::in_t  in_data_s1;
	logic          in_valid_s1;
	logic          out_valid_q;
	logic          advance;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// step moves into the result register when that register is free
	assign advance  = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				in_valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_data_s1 <= in_data;
	end

	bpc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (in_data_s1),
		.cfg     (cfg),
		.result  (out_data)
	);

	assign out_valid = out_valid_q;

endmodule
